/* design/itp_pkg.sv */
// Shared types, codes and sizes for the infix to postfix converter.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package itp_pkg;

    // Sizes
    localparam int STACK_DEPTH = 16;
    localparam int TAG_WIDTH   = 32;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Tag bits kept from the 32-bit field
    localparam logic [31:0] TAG_MASK = (TAG_WIDTH >= 32) ? 32'hFFFF_FFFF
                                       : 32'((64'd1 << TAG_WIDTH) - 64'd1);

    typedef logic [1:0] cmd_t;
    typedef logic [2:0] op_t;
    typedef logic [1:0] kind_t;
    typedef logic [1:0] err_t;
    typedef logic [1:0] prec_t;

    // Token commands
    localparam cmd_t CMD_OPERAND  = 2'd0;
    localparam cmd_t CMD_OPERATOR = 2'd1;
    localparam cmd_t CMD_END      = 2'd2;

    // Operator codes
    localparam op_t OP_ADD   = 3'd0;
    localparam op_t OP_SUB   = 3'd1;
    localparam op_t OP_MUL   = 3'd2;
    localparam op_t OP_DIV   = 3'd3;
    localparam op_t OP_POW   = 3'd4;
    localparam op_t OP_MOD   = 3'd5;
    localparam op_t OP_OPEN  = 3'd6;
    localparam op_t OP_CLOSE = 3'd7;

    // Result kinds
    localparam kind_t KIND_OPERAND  = 2'd0;
    localparam kind_t KIND_OPERATOR = 2'd1;
    localparam kind_t KIND_NONE     = 2'd2;

    // Fault codes
    localparam err_t ERR_NONE            = 2'd0;
    localparam err_t ERR_OVERFLOW        = 2'd1;
    localparam err_t ERR_UNMATCHED_CLOSE = 2'd2;
    localparam err_t ERR_UNMATCHED_OPEN  = 2'd3;

    // Binding strength; the opening parenthesis binds weakest
    function automatic prec_t precedence(input op_t op);
        prec_t p;
        case (op)
            OP_POW:                 p = 2'd3;
            OP_MUL, OP_DIV, OP_MOD: p = 2'd2;
            OP_ADD, OP_SUB:         p = 2'd1;
            default:                p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

/* design/itp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the operator stack of the converter.
`timescale 1ns / 1ps

module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, register read data on enable
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/infix_to_postfix_converter.sv */
// Shunting-yard infix to postfix converter: top level with the stack sequencer.
// Depends on itp_pkg and on itp_ram for the operator stack.
// An operand item's result is registered and appears in the cycle after acceptance.
// An operator item is accepted, then stack entries are examined in ST_EVAL (one stack
//   RAM read each, waiting while the output is full) and ST_FIN closes its results.
// Results leave through an output register; items are taken only while it can load.
// Reset: stack count cleared, stack RAM contents left undefined, no clearing pass.
`timescale 1ns / 1ps

module infix_to_postfix_converter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,   // op_code[2:0], operand_tag[34:3], zero pad
    input  itp_pkg::cmd_t       s_tuser,   // cmd[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // out_op[2:0], out_tag[34:3], error[36:35], pad
    output itp_pkg::kind_t      m_tuser,   // out_kind[1:0]
    output logic                m_tlast
);

    import itp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Control state
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             hold_valid_reg, hold_valid_next;
    logic             m_valid_reg, m_valid_next;

    // Item and result context
    cmd_t  cmd_reg, cmd_next;
    op_t   op_reg, op_next;
    err_t  err_reg, err_next;
    op_t   hold_op_reg, hold_op_next;

    // Output payload
    kind_t       m_kind_reg;
    op_t         m_op_reg;
    logic [31:0] m_tag_reg;
    logic        m_last_reg;
    err_t        m_err_reg;

    // Stack RAM port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    op_t              ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    op_t              top_op;

    // Helpers
    logic             s_accept;
    logic             out_free;
    logic             out_load;
    kind_t            out_kind_d;
    op_t              out_op_d;
    logic [31:0]      out_tag_d;
    logic             out_last_d;
    err_t             out_err_d;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;
    logic             top_open;
    logic             pop_ok;
    logic             ev_emit;
    logic             ev_stop;
    op_t              in_op;
    logic [31:0]      in_tag;

    assign in_op  = s_tdata[2:0];
    assign in_tag = s_tdata[34:3] & TAG_MASK;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    assign cnt_m1   = count_reg - CNT_ONE;
    assign cnt_m2   = count_reg - CNT_W'(2);
    assign top_open = (top_op == OP_OPEN);
    assign pop_ok   = !top_open && (precedence(top_op) >= precedence(op_reg))
                      && !((op_reg == OP_POW) && (top_op == OP_POW));

    itp_ram #(
        .WIDTH(3),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(top_op)
    );

    // Sequence one item: examine the stack top, pop, push, close the run
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        hold_valid_next = hold_valid_reg;
        hold_op_next    = hold_op_reg;
        cmd_next        = cmd_reg;
        op_next         = op_reg;
        err_next        = err_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[IDX_W-1:0];
        ram_wdata       = op_reg;
        ram_re          = 1'b0;
        ram_raddr       = cnt_m1[IDX_W-1:0];
        out_load        = 1'b0;
        out_kind_d      = KIND_NONE;
        out_op_d        = OP_ADD;
        out_tag_d       = 32'd0;
        out_last_d      = 1'b1;
        out_err_d       = ERR_NONE;
        ev_emit         = 1'b0;
        ev_stop         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_next        = s_tuser;
                    op_next         = in_op;
                    err_next        = ERR_NONE;
                    hold_valid_next = 1'b0;
                    case (s_tuser)
                        CMD_OPERAND: begin
                            out_load   = 1'b1;
                            out_kind_d = KIND_OPERAND;
                            out_tag_d  = in_tag;
                        end
                        CMD_OPERATOR: begin
                            if (in_op == OP_CLOSE) begin
                                if (count_reg == '0) begin
                                    out_load  = 1'b1;
                                    out_err_d = ERR_UNMATCHED_CLOSE;
                                end else begin
                                    ram_re     = 1'b1;
                                    state_next = ST_EVAL;
                                end
                            end else if ((in_op == OP_OPEN) || (count_reg == '0)) begin
                                if (count_reg == CNT_FULL) begin
                                    out_load  = 1'b1;
                                    out_err_d = ERR_OVERFLOW;
                                end else begin
                                    ram_we     = 1'b1;
                                    ram_wdata  = in_op;
                                    count_next = count_reg + CNT_ONE;
                                end
                            end else begin
                                ram_re     = 1'b1;
                                state_next = ST_EVAL;
                            end
                        end
                        CMD_END: begin
                            if (count_reg != '0) begin
                                ram_re     = 1'b1;
                                state_next = ST_EVAL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_EVAL: begin
                if (out_free) begin
                    if (cmd_reg == CMD_END) begin
                        // Flush: drop open parentheses, emit the rest
                        count_next = cnt_m1;
                        if (top_open) begin
                            err_next = ERR_UNMATCHED_OPEN;
                        end else begin
                            ev_emit = 1'b1;
                        end
                        ev_stop = (count_reg == CNT_ONE);
                    end else if (op_reg == OP_CLOSE) begin
                        // Unwind to the matching opening parenthesis
                        count_next = cnt_m1;
                        if (top_open) begin
                            ev_stop = 1'b1;
                        end else begin
                            ev_emit = 1'b1;
                            if (count_reg == CNT_ONE) begin
                                err_next = ERR_UNMATCHED_CLOSE;
                                ev_stop  = 1'b1;
                            end
                        end
                    end else if (pop_ok) begin
                        // Pop a stronger or equal operator; push into its slot if the stack drains
                        ev_emit = 1'b1;
                        if (count_reg == CNT_ONE) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ev_stop   = 1'b1;
                        end else begin
                            count_next = cnt_m1;
                        end
                    end else begin
                        // Push above the remaining entries
                        ev_stop = 1'b1;
                        if (count_reg == CNT_FULL) begin
                            err_next = ERR_OVERFLOW;
                        end else begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_ONE;
                        end
                    end

                    // Release the held result and hold the popped operator
                    if (ev_emit) begin
                        if (hold_valid_reg) begin
                            out_load   = 1'b1;
                            out_kind_d = KIND_OPERATOR;
                            out_op_d   = hold_op_reg;
                            out_last_d = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_op_next    = top_op;
                    end

                    if (ev_stop) begin
                        state_next = (hold_valid_next || (err_next != ERR_NONE))
                                     ? ST_FIN : ST_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = cnt_m2[IDX_W-1:0];
                    end
                end
            end

            ST_FIN: begin
                // Send the final result with the fault code
                if (out_free) begin
                    out_load        = 1'b1;
                    out_err_d       = err_reg;
                    hold_valid_next = 1'b0;
                    if (hold_valid_reg) begin
                        out_kind_d = KIND_OPERATOR;
                        out_op_d   = hold_op_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: load on a new result, drop when taken
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Context and payload registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        op_reg      <= op_next;
        err_reg     <= err_next;
        hold_op_reg <= hold_op_next;
        if (out_load) begin
            m_kind_reg <= out_kind_d;
            m_op_reg   <= out_op_d;
            m_tag_reg  <= out_tag_d;
            m_last_reg <= out_last_d;
            m_err_reg  <= out_err_d;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_err_reg, m_tag_reg, m_op_reg};

`ifndef SYNTHESIS
    // Stack count never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("stack count beyond depth");

    // No held result survives into the idle state
    a_hold_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held result left behind");

    // Stack examination only runs on a non-empty stack
    a_eval_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> (count_reg != '0))
        else $error("stack read while empty");

    // An empty result carries a fault and closes its run
    a_none_has_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg == KIND_NONE)) |-> (m_last_reg && (m_err_reg != ERR_NONE)))
        else $error("empty result without fault");

    // Faults only ride on the final result
    a_err_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_err_reg != ERR_NONE)) |-> m_last_reg)
        else $error("fault on a non-final result");

    // Closing cycle always hands a result to the output
    a_fin_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=> (m_valid_reg && m_last_reg))
        else $error("closing cycle sent nothing");
`endif

endmodule

/* tb/postfix_checker.sv */
// Scoreboard for the infix to postfix converter: watches both streams, predicts
// the postfix items of every accepted token and compares them in order.
// Depends on itp_pkg for codes, widths and the tag mask.
`timescale 1ns / 1ps

module postfix_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [39:0]    s_tdata,   // op_code[2:0], operand_tag[34:3], zero pad
    input  itp_pkg::cmd_t  s_tuser,   // cmd[1:0]
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [39:0]    m_tdata,   // out_op[2:0], out_tag[34:3], error[36:35], pad
    input  itp_pkg::kind_t m_tuser,   // out_kind[1:0]
    input  logic           m_tlast,
    output int             fail_count,
    output int             pending,
    output int             token_count,
    output int             fault_count
);

    import itp_pkg::*;

    typedef struct packed {
        kind_t       kind;
        op_t         op;
        logic [31:0] tag;
        logic        last;
        err_t        err;
    } postfix_item_t;

    // Shadow of the operator stack
    op_t op_stack [STACK_DEPTH];
    int  depth;

    postfix_item_t postfix_q [$];   // items still owed by the block
    postfix_item_t run_q [$];       // items of the token being converted

    int n_fail;
    int n_tokens;
    int n_faults;

    // Binding strength, '(' weakest
    function automatic int binding(input op_t op);
        int rank;
        rank = 0;
        if (op == OP_POW)
            rank = 3;
        else if (op == OP_MUL || op == OP_DIV || op == OP_MOD)
            rank = 2;
        else if (op == OP_ADD || op == OP_SUB)
            rank = 1;
        return rank;
    endfunction

    function automatic postfix_item_t make_item(input kind_t kind, input op_t op,
                                                input logic [31:0] tag);
        postfix_item_t it;
        it.kind = kind;
        it.op   = op;
        it.tag  = tag;
        it.last = 1'b0;
        it.err  = ERR_NONE;
        return it;
    endfunction

    // Append an item to the run of the current token
    task automatic add_to_run(input postfix_item_t it);
        run_q.insert(run_q.size(), it);
    endtask

    // Take the top operator off the stack and emit it
    task automatic pop_emit();
        depth = depth - 1;
        add_to_run(make_item(KIND_OPERATOR, op_stack[depth], 32'd0));
    endtask

    // Work out the postfix items that one token causes
    task automatic convert_token(input cmd_t cmd, input op_t op, input logic [31:0] tag);
        err_t          err;
        logic          found;
        postfix_item_t tail;
        err = ERR_NONE;
        run_q.delete();
        case (cmd)
            CMD_OPERAND: begin
                add_to_run(make_item(KIND_OPERAND, OP_ADD, tag & TAG_MASK));
            end
            CMD_OPERATOR: begin
                if (op == OP_CLOSE) begin
                    // Unwind to the matching '('
                    found = 1'b0;
                    while (depth > 0 && !found) begin
                        if (op_stack[depth - 1] == OP_OPEN) begin
                            depth = depth - 1;
                            found = 1'b1;
                        end else begin
                            pop_emit();
                        end
                    end
                    if (!found)
                        err = ERR_UNMATCHED_CLOSE;
                end else begin
                    // Pop stronger or equal operators; '^' binds to the right
                    if (op != OP_OPEN) begin
                        while (depth > 0 && op_stack[depth - 1] != OP_OPEN &&
                               binding(op_stack[depth - 1]) >= binding(op) &&
                               !(op == OP_POW && op_stack[depth - 1] == OP_POW))
                            pop_emit();
                    end
                    if (depth >= STACK_DEPTH) begin
                        err = ERR_OVERFLOW;
                    end else begin
                        op_stack[depth] = op;
                        depth = depth + 1;
                    end
                end
            end
            CMD_END: begin
                // Flush, dropping any open parentheses
                while (depth > 0) begin
                    if (op_stack[depth - 1] == OP_OPEN) begin
                        depth = depth - 1;
                        err = ERR_UNMATCHED_OPEN;
                    end else begin
                        pop_emit();
                    end
                end
            end
            default: begin
                return;
            end
        endcase
        if (run_q.size() == 0 && err != ERR_NONE)
            add_to_run(make_item(KIND_NONE, OP_ADD, 32'd0));
        if (run_q.size() > 0) begin
            tail = run_q.pop_back();
            tail.last = 1'b1;
            tail.err  = err;
            add_to_run(tail);
        end
        foreach (run_q[i])
            postfix_q.insert(postfix_q.size(), run_q[i]);
    endtask

    // Sample both streams at the edge; tokens before results
    always @(posedge aclk) begin
        postfix_item_t want;
        postfix_item_t got;
        if (!aresetn) begin
            depth = 0;
            postfix_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                convert_token(s_tuser, s_tdata[2:0], s_tdata[34:3]);
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser;
                got.op   = m_tdata[2:0];
                got.tag  = m_tdata[34:3];
                got.last = m_tlast;
                got.err  = m_tdata[36:35];
                n_tokens = n_tokens + 1;
                if (got.err != ERR_NONE)
                    n_faults = n_faults + 1;
                if (postfix_q.size() == 0) begin
                    n_fail = n_fail + 1;
                    if (n_fail <= 10)
                        $display(
                            "%0t: unexpected item kind %0d op %0d tag %h last %0d err %0d",
                            $time, got.kind, got.op, got.tag, got.last, got.err);
                end else begin
                    want = postfix_q.pop_front();
                    if (got.kind != want.kind || got.op != want.op || got.tag != want.tag ||
                        got.last != want.last || got.err != want.err) begin
                        n_fail = n_fail + 1;
                        if (n_fail <= 10) begin
                            $display("%0t: expected kind %0d op %0d tag %h last %0d err %0d",
                                     $time, want.kind, want.op, want.tag, want.last, want.err);
                            $display("%0t: got      kind %0d op %0d tag %h last %0d err %0d",
                                     $time, got.kind, got.op, got.tag, got.last, got.err);
                        end
                    end
                end
            end
        end
        fail_count  <= n_fail;
        pending     <= postfix_q.size();
        token_count <= n_tokens;
        fault_count <= n_faults;
    end

endmodule

/* tb/infix_to_postfix_converter_tb.sv */
// Testbench top for the infix to postfix converter: clock, reset, token stimulus
// with random idling on both sides, and the verdict. Depends on itp_pkg, the
// converter and postfix_checker.
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;

    import itp_pkg::*;

    localparam cmd_t CMD_UNUSED   = 2'd3;
    localparam int   DIRECTED     = 23;
    localparam int   RANDOM_ITEMS = 220;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   DRAIN_CYCLES = 24;
    localparam int   LIMIT        = 400000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    cmd_t        s_tuser  = CMD_OPERAND;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    kind_t       m_tuser;
    logic        m_tlast;

    int   fail_count;
    int   pending;
    int   token_count;
    int   fault_count;
    int   items_sent   = 0;
    int   ignored_sent = 0;
    int   cycle_count  = 0;
    int   rx_count     = 0;
    logic hold_rx      = 1'b0;

    infix_to_postfix_converter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    postfix_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .token_count (token_count),
        .fault_count (fault_count)
    );

    always #5 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Timed out after %0d cycles with %0d items outstanding",
                     cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one token after a random gap and hold it until taken
    task automatic send_token(input cmd_t cmd, input op_t op, input logic [31:0] tag);
        int gap;
        gap = (items_sent % 50 < 12) ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, tag, op};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_UNUSED)
            ignored_sent = ignored_sent + 1;
        else
            items_sent = items_sent + 1;
    endtask

    task automatic send_operator(input op_t op);
        send_token(CMD_OPERATOR, op, $urandom());
    endtask

    task automatic send_operand(input logic [31:0] tag);
        send_token(CMD_OPERAND, op_t'($urandom()), tag);
    endtask

    // Push a run of '(' and '^' past the stack depth, then close some and end
    task automatic send_deep();
        int n;
        for (n = 0; n < STACK_DEPTH + 2; n++)
            send_operator($urandom_range(0, 1) ? OP_OPEN : OP_POW);
        repeat ($urandom_range(0, 3))
            send_operator(OP_CLOSE);
        send_token(CMD_END, op_t'($urandom()), $urandom());
    endtask

    // Mostly well-formed expression with a sprinkle of noise tokens
    task automatic send_expression(input int max_len);
        int   nest;
        int   n;
        logic want_operand;
        nest = 0;
        want_operand = 1'b1;
        for (n = 0; n < max_len; n++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_token(cmd_t'($urandom_range(0, 3)), op_t'($urandom()), $urandom());
            end else if (want_operand) begin
                if (nest < 6 && $urandom_range(0, 3) == 0) begin
                    send_operator(OP_OPEN);
                    nest = nest + 1;
                end else begin
                    send_operand($urandom());
                    want_operand = 1'b0;
                end
            end else if (nest > 0 && $urandom_range(0, 2) == 0) begin
                send_operator(OP_CLOSE);
                nest = nest - 1;
            end else begin
                send_operator(op_t'($urandom_range(OP_ADD, OP_MOD)));
                want_operand = 1'b1;
            end
        end
        if (want_operand)
            send_operand($urandom());
        // Leave a parenthesis open now and then
        while (nest > 0 && $urandom_range(0, 4) != 0) begin
            send_operator(OP_CLOSE);
            nest = nest - 1;
        end
        send_token(CMD_END, op_t'($urandom()), $urandom());
    endtask

    // Receiver: random gaps, bursts of back-to-back takes, one long hold
    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            gap = (rx_count % 45 < 10) ? 0 : $urandom_range(0, 12);
            repeat (gap) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end
            while (hold_rx) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            rx_count = rx_count + 1;
        end
    end

    // Starve the output once so the block backs up into its input
    initial begin
        while (items_sent < DIRECTED + 40)
            @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // a - ( b / c % d ) ^ e ^ f ) : precedence, '%' with '/', right-assoc '^',
        // then an unmatched close that unwinds everything
        send_operand(32'd0);
        send_operator(OP_SUB);
        send_operator(OP_OPEN);
        send_operand($urandom());
        send_operator(OP_DIV);
        send_operand($urandom());
        send_operator(OP_MOD);
        send_operand($urandom());
        send_operator(OP_CLOSE);
        send_operator(OP_POW);
        send_operand($urandom());
        send_operator(OP_POW);
        send_operand(32'hFFFF_FFFF);
        send_operator(OP_CLOSE);
        // Close on an empty stack: fault on an empty result
        send_operator(OP_CLOSE);
        // ( * + end : emits '*' then '+' with an unmatched open
        send_operator(OP_OPEN);
        send_operator(OP_MUL);
        send_operator(OP_ADD);
        send_token(CMD_END, OP_ADD, 32'd0);
        // Unused command, end on empty stack, lone open parenthesis
        send_token(CMD_UNUSED, OP_CLOSE, 32'hFFFF_FFFF);
        send_token(CMD_END, OP_CLOSE, 32'hFFFF_FFFF);
        send_operator(OP_OPEN);
        send_token(CMD_END, OP_ADD, 32'd0);

        // Random part, opening with a stack overflow
        send_deep();
        while (items_sent < DIRECTED + RANDOM_ITEMS) begin
            if ($urandom_range(0, 11) == 0)
                send_deep();
            else
                send_expression($urandom_range(3, 14));
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for a late stray item
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run sent %0d tokens (plus %0d ignored) and checked %0d postfix items,",
                 items_sent, ignored_sent, token_count);
        $display("%0d of them carrying a fault code; %0d mismatches.",
                 fault_count, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
